FILE: design/asrhf_pkg.sv
// Shared types, codes and constants for the actuator stall, retry and homing sequencer.
package asrhf_pkg;

  // Fixed motion constants.
  localparam int BACKOFF             = 40;
  localparam int HOME_SETTLE         = 2000;
  localparam int HOME_RETURN_TIMEOUT = 10000;
  localparam int HOME_SEEK_TIMEOUT   = 5000;

  localparam logic signed [8:0]  HOMING_DRIVE    = 9'sd120;
  localparam logic signed [15:0] HOMING_SETPOINT = -16'sd1000;
  localparam logic signed [8:0]  DRIVE_MIN       = -9'sd255;
  localparam logic signed [8:0]  DRIVE_OVER      = -9'sd256;

  // Input word modes.
  localparam logic [1:0] MODE_TICK   = 2'd0;
  localparam logic [1:0] MODE_TARGET = 2'd1;
  localparam logic [1:0] MODE_HOME   = 2'd2;

  // Status codes.
  localparam logic [1:0] ERR_OK      = 2'd0;
  localparam logic [1:0] ERR_HOMING  = 2'd1;
  localparam logic [1:0] ERR_BLOCKED = 2'd2;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_TICK_PERIOD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STALL_TIME  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_TARGET  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HOME_RELOAD = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_REVERSE_DIR = 3'd5;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [2:0] {
    S_NORMAL   = 3'd0,
    S_ATTEMPT  = 3'd1,
    S_ATT_RET  = 3'd2,
    S_HOME_RET = 3'd3,
    S_HOMING   = 3'd4,
    S_ERROR    = 3'd5
  } fsm_state_t;

  typedef struct packed {
    logic [15:0]        tick_period;
    logic [15:0]        stall_time;
    logic [7:0]         retry_limit;
    logic [14:0]        max_target;
    logic signed [15:0] home_reload;
    logic               reverse_dir;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    tick_period: 16'd10,
    stall_time:  16'd500,
    retry_limit: 8'd3,
    max_target:  15'd2000,
    home_reload: -16'sd100,
    reverse_dir: 1'b0
  };

  typedef struct packed {
    logic [1:0]         mode;
    logic [15:0]        now_time;
    logic signed [15:0] position;
    logic signed [15:0] enc_speed;
    logic signed [8:0]  pid_drive;
    logic signed [15:0] target;
  } item_t;

  typedef struct packed {
    fsm_state_t         fsm_state;
    logic signed [15:0] target_pos;
    logic signed [15:0] stuck_pos;
    logic [15:0]        still_time;
    logic [15:0]        home_time;
    logic [7:0]         retries;
    logic [15:0]        prev_time;
    logic signed [8:0]  drive;
    logic signed [8:0]  prev_drive;
    logic [1:0]         err_code;
    logic signed [15:0] cur_setpoint;
  } seq_state_t;

  localparam seq_state_t STATE_RESET = '{
    fsm_state:    S_NORMAL,
    target_pos:   16'sd0,
    stuck_pos:    16'sd0,
    still_time:   16'd0,
    home_time:    16'd0,
    retries:      8'd0,
    prev_time:    16'd0,
    drive:        9'sd0,
    prev_drive:   9'sd0,
    err_code:     ERR_OK,
    cur_setpoint: 16'sd0
  };

  typedef struct packed {
    logic signed [15:0] setpoint;
    logic               pid_advance;
    logic               direction;
    logic [7:0]         duty;
    logic               duty_write;
    logic               enc_load;
    logic signed [15:0] enc_load_value;
    logic [1:0]         status;
    logic signed [15:0] cur_target;
  } result_t;

  // Timer add that sticks at the top of the 16-bit range.
  function automatic logic [15:0] tadd16(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

  // Saturates a 17-bit signed value into 16 bits.
  function automatic logic signed [15:0] sat16(input logic signed [16:0] v);
    logic signed [15:0] r;
    if (v[16] != v[15]) begin
      r = v[16] ? 16'sh8000 : 16'sh7FFF;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

FILE: design/actuator_stall_retry_homing_fsm.sv
// Top level of the actuator stall, retry and homing sequencer.
//
// Input channel: in_valid / in_stall with the fields mode, now_time, position,
// enc_speed, pid_drive and target. A word is taken when in_valid is high and
// in_stall is low. Each input word gives exactly one result word on the
// output channel (out_valid / out_stall), carrying setpoint, pid_advance,
// direction, duty, duty_write, enc_load, enc_load_value, status and cur_target.
//
// A taken word sits in an input register; when the result register is empty
// or not stalled, the sequencer logic evaluates it, updates the state and
// loads the result register. One word per cycle is sustained while out_stall is
// low, set by the single state update per word.
//
// When the receiver stalls, the result register holds its word and the input
// register can still take one more word; in_stall rises only when both are
// full. Configuration is written through cfg_we, cfg_index and cfg_data at
// any edge with cfg_we high; it should be changed only while the block is idle.
//
// Synchronous reset returns the sequencer to the normal state with all timers,
// positions and drive cleared, restores the register defaults and empties
// both the input and result registers.
module actuator_stall_retry_homing_fsm (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [asrhf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [asrhf_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [1:0]                           mode,
  input  logic [15:0]                          now_time,
  input  logic signed [15:0]                   position,
  input  logic signed [15:0]                   enc_speed,
  input  logic signed [8:0]                    pid_drive,
  input  logic signed [15:0]                   target,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [15:0]                   setpoint,
  output logic                                 pid_advance,
  output logic                                 direction,
  output logic [7:0]                           duty,
  output logic                                 duty_write,
  output logic                                 enc_load,
  output logic signed [15:0]                   enc_load_value,
  output logic [1:0]                           status,
  output logic signed [15:0]                   cur_target
);
  import asrhf_pkg::*;

  cfg_t       cfg;
  seq_state_t st;
  seq_state_t st_next;
  item_t      in_word;
  logic       in_full;
  result_t    res_next;
  result_t    res_word;
  logic       advance;
  logic       accept;

  assign advance  = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TICK_PERIOD: cfg.tick_period <= cfg_data;
        CFG_STALL_TIME:  cfg.stall_time  <= cfg_data;
        CFG_RETRY_LIMIT: cfg.retry_limit <= cfg_data[7:0];
        CFG_MAX_TARGET:  cfg.max_target  <= cfg_data[14:0];
        CFG_HOME_RELOAD: cfg.home_reload <= signed'(cfg_data);
        CFG_REVERSE_DIR: cfg.reverse_dir <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (accept) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_word <= '{mode: mode, now_time: now_time, position: position,
                   enc_speed: enc_speed, pid_drive: pid_drive, target: target};
    end
  end

  asrhf_step u_step (
    .cfg  (cfg),
    .st   (st),
    .item (in_word),
    .nx   (st_next),
    .res  (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= STATE_RESET;
    end else if (advance) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_word <= res_next;
    end
  end

  assign setpoint       = res_word.setpoint;
  assign pid_advance    = res_word.pid_advance;
  assign direction      = res_word.direction;
  assign duty           = res_word.duty;
  assign duty_write     = res_word.duty_write;
  assign enc_load       = res_word.enc_load;
  assign enc_load_value = res_word.enc_load_value;
  assign status         = res_word.status;
  assign cur_target     = res_word.cur_target;

endmodule

FILE: design/asrhf_step.sv
// Combinational next-state and result logic for one word of the sequencer.
module asrhf_step (
  input  asrhf_pkg::cfg_t       cfg,
  input  asrhf_pkg::seq_state_t st,
  input  asrhf_pkg::item_t      item,
  output asrhf_pkg::seq_state_t nx,
  output asrhf_pkg::result_t    res
);
  import asrhf_pkg::*;

  localparam logic signed [16:0] BACKOFF_W   = 17'(BACKOFF);
  localparam logic [15:0]        SETTLE_W    = 16'(HOME_SETTLE);
  localparam logic [15:0]        RET_TMO_W   = 16'(HOME_RETURN_TIMEOUT);
  localparam logic [15:0]        SEEK_TMO_W  = 16'(HOME_SEEK_TIMEOUT);

  logic signed [8:0]  pd;
  logic signed [15:0] max_s;
  logic signed [15:0] tgt_c;
  logic [15:0]        delta;
  logic               tick_due;
  logic [15:0]        still_sum;
  logic [15:0]        home_sum;
  logic               stalled;
  logic signed [16:0] pos_x;
  logic signed [16:0] stuck_x;
  logic signed [16:0] diff;
  logic signed [16:0] pos_gap;
  logic signed [15:0] bo_setpoint;
  logic               retry_left;
  logic [7:0]         retries_inc;
  logic signed [8:0]  dabs;

  always_comb begin
    pd        = (item.pid_drive == DRIVE_OVER) ? DRIVE_MIN : item.pid_drive;
    max_s     = signed'({1'b0, cfg.max_target});
    tgt_c     = (item.target > max_s) ? max_s : item.target;
    delta     = item.now_time - st.prev_time;
    tick_due  = (delta >= cfg.tick_period);
    still_sum = tadd16(st.still_time, delta);
    home_sum  = tadd16(st.home_time, delta);
    stalled   = (pd != 9'sd0) && (item.enc_speed == 16'sd0);
    pos_x     = {item.position[15], item.position};
    stuck_x   = {st.stuck_pos[15], st.stuck_pos};
    diff      = pos_x - stuck_x;
    pos_gap   = diff[16] ? -diff : diff;
    // Back off away from the target side of the stall point.
    bo_setpoint = (item.position < st.target_pos) ? sat16(pos_x - BACKOFF_W)
                                                  : sat16(pos_x + BACKOFF_W);
    retry_left  = (({1'b0, st.retries} + 9'd1) < {1'b0, cfg.retry_limit});
    retries_inc = (st.retries == 8'hFF) ? st.retries : st.retries + 8'd1;

    nx                 = st;
    res.pid_advance    = 1'b0;
    res.duty_write     = 1'b0;
    res.enc_load       = 1'b0;
    res.enc_load_value = 16'sd0;

    case (item.mode)
      MODE_TARGET: begin
        if ((st.fsm_state == S_NORMAL || st.fsm_state == S_ERROR) &&
            tgt_c != st.target_pos) begin
          nx.target_pos   = tgt_c;
          nx.fsm_state    = S_NORMAL;
          nx.err_code     = ERR_OK;
          nx.retries      = 8'd0;
          nx.cur_setpoint = tgt_c;
        end
      end
      MODE_HOME: begin
        if (st.fsm_state != S_HOME_RET && st.fsm_state != S_HOMING) begin
          nx.fsm_state    = S_HOME_RET;
          nx.err_code     = ERR_HOMING;
          nx.home_time    = 16'd0;
          nx.still_time   = 16'd0;
          nx.target_pos   = 16'sd0;
          nx.cur_setpoint = HOMING_SETPOINT;
        end
      end
      MODE_TICK: begin
        if (tick_due) begin
          nx.prev_time = item.now_time;
          if (st.fsm_state inside {S_NORMAL, S_ATTEMPT, S_ATT_RET, S_HOME_RET}) begin
            nx.drive        = pd;
            res.pid_advance = 1'b1;
          end
          case (st.fsm_state)
            S_NORMAL: begin
              if (stalled) begin
                if (still_sum >= cfg.stall_time) begin
                  nx.still_time   = 16'd0;
                  nx.retries      = 8'd0;
                  nx.stuck_pos    = item.position;
                  nx.cur_setpoint = bo_setpoint;
                  nx.fsm_state    = S_ATT_RET;
                end else begin
                  nx.still_time = still_sum;
                end
              end else begin
                nx.still_time = 16'd0;
              end
            end
            S_ATTEMPT: begin
              // The stall timer keeps its count while the motor moves here.
              if (stalled) begin
                if (still_sum >= cfg.stall_time) begin
                  nx.retries    = retries_inc;
                  nx.still_time = 16'd0;
                  if (retry_left) begin
                    nx.stuck_pos    = item.position;
                    nx.cur_setpoint = bo_setpoint;
                    nx.fsm_state    = S_ATT_RET;
                  end else begin
                    nx.drive     = 9'sd0;
                    nx.err_code  = ERR_BLOCKED;
                    nx.fsm_state = S_ERROR;
                  end
                end else begin
                  nx.still_time = still_sum;
                end
              end
            end
            S_ATT_RET: begin
              if (pos_gap >= BACKOFF_W) begin
                nx.cur_setpoint = st.target_pos;
                nx.fsm_state    = S_ATTEMPT;
              end
            end
            S_HOME_RET: begin
              if (item.enc_speed == 16'sd0) begin
                if (still_sum >= SETTLE_W) begin
                  nx.home_time  = 16'd0;
                  nx.still_time = 16'd0;
                  res.enc_load  = 1'b1;
                  nx.drive      = HOMING_DRIVE;
                  nx.fsm_state  = S_HOMING;
                end else begin
                  nx.still_time = still_sum;
                end
              end else begin
                nx.home_time  = home_sum;
                nx.still_time = 16'd0;
                if (home_sum >= RET_TMO_W) begin
                  nx.drive     = 9'sd0;
                  res.enc_load = 1'b1;
                  nx.err_code  = ERR_BLOCKED;
                  nx.fsm_state = S_ERROR;
                end
              end
            end
            S_HOMING: begin
              if (item.position > 16'sd0) begin
                nx.drive           = 9'sd0;
                res.enc_load       = 1'b1;
                res.enc_load_value = cfg.home_reload;
                nx.cur_setpoint    = 16'sd0;
                nx.still_time      = 16'd0;
                nx.err_code        = ERR_OK;
                nx.fsm_state       = S_NORMAL;
              end else begin
                nx.home_time = home_sum;
                if (home_sum >= SEEK_TMO_W) begin
                  nx.drive     = 9'sd0;
                  res.enc_load = 1'b1;
                  nx.err_code  = ERR_BLOCKED;
                  nx.fsm_state = S_ERROR;
                end
              end
            end
            default: begin
              nx.drive = 9'sd0;
            end
          endcase
          if (nx.drive != st.prev_drive) begin
            res.duty_write = 1'b1;
            nx.prev_drive  = nx.drive;
          end
        end
      end
      default: begin
      end
    endcase

    dabs          = nx.drive[8] ? -nx.drive : nx.drive;
    res.duty      = dabs[7:0];
    res.direction = ((nx.drive > 9'sd0 && !cfg.reverse_dir) ||
                     (nx.drive < 9'sd0 && cfg.reverse_dir)) ? 1'b0 : 1'b1;
    res.setpoint   = nx.cur_setpoint;
    res.status     = nx.err_code;
    res.cur_target = nx.target_pos;
  end

endmodule

FILE: design/asrhf_checker.sv
// Port-level checks for the sequencer, bound to the top level.
module asrhf_checker (
  input logic                clk,
  input logic                rst,
  input logic                out_valid,
  input logic                out_stall,
  input logic signed [15:0]  setpoint,
  input logic [7:0]          duty,
  input logic                enc_load,
  input logic [1:0]          status,
  input logic signed [15:0]  cur_target
);
  import asrhf_pkg::*;

  // A stalled result word must stay put.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(setpoint) && $stable(status))
    else $error("result word changed while stalled");

  // While homing runs the target is cleared and the setpoint is the homing one.
  a_homing: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ERR_HOMING |-> cur_target == 16'sd0 &&
                                          setpoint == HOMING_SETPOINT)
    else $error("homing status with unexpected target or setpoint");

  // A reload reported with status ok can only be the end of homing, drive off.
  a_reload: assert property (@(posedge clk) disable iff (rst)
    out_valid && enc_load && status == ERR_OK |-> duty == 8'd0 && setpoint == 16'sd0)
    else $error("encoder reload with ok status while driving");

  // Reset empties the result register.
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid just after reset");

endmodule

bind actuator_stall_retry_homing_fsm asrhf_checker u_asrhf_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .setpoint   (setpoint),
  .duty       (duty),
  .enc_load   (enc_load),
  .status     (status),
  .cur_target (cur_target)
);
